// ===== rtl/core/opc_sp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the serpentine pixel-stream receiver.
// No dependencies; imported by every module of the block.
package opc_sp_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_WIDTH_W = 11;
  localparam int PIX_X_W     = 10;
  localparam int PIX_Y_W     = 15;
  localparam int LEN_W       = 16;
  localparam int TRIPLE_W    = 2;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int OUT_DATA_W  = 56;
  localparam int DEF_MAX_WIDTH = 1024;

  localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET = CFG_WIDTH_W'(64);

  // Register indexes, taken from paddr[2]
  localparam logic REG_DISPLAY_WIDTH = 1'b0;

  // Position inside an RGB triple
  localparam logic [TRIPLE_W-1:0] TRIP_RED   = 2'd0;
  localparam logic [TRIPLE_W-1:0] TRIP_GREEN = 2'd1;
  localparam logic [TRIPLE_W-1:0] TRIP_BLUE  = 2'd2;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_HDR2    = 5'b00100,
    PH_HDR3    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic               pixel_valid;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
    logic               frame_end;
  } result_t;

endpackage

// ===== rtl/core/opc_sp_cfg.sv =====
`timescale 1ns / 1ps
// APB register file holding the display width.
// Depends on opc_sp_pkg.
module opc_sp_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [opc_sp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [opc_sp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [opc_sp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                 pready,
  output logic [opc_sp_pkg::CFG_WIDTH_W-1:0]   display_width
);
  import opc_sp_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_DISPLAY_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width <= WIDTH_RESET;
    end else if (wr_en) begin
      display_width <= pwdata[CFG_WIDTH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DISPLAY_WIDTH) begin
      prdata = APB_DATA_W'(display_width);
    end
  end

endmodule

// ===== rtl/core/opc_sp_parse.sv =====
`timescale 1ns / 1ps
// Input register, header/payload parser and serpentine coordinate mapper.
// Depends on opc_sp_pkg.
module opc_sp_parse #(
  parameter int MAX_WIDTH = opc_sp_pkg::DEF_MAX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [opc_sp_pkg::BYTE_W-1:0]       s_tdata,
  input  logic [opc_sp_pkg::CFG_WIDTH_W-1:0]  display_width,
  input  logic                                res_full,
  output logic                                res_push,
  output opc_sp_pkg::result_t                 res
);
  import opc_sp_pkg::*;

  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW = 17;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;

  // parser state
  phase_t              phase, phase_next;
  logic [BYTE_W-1:0]   length_high, length_high_next;
  logic [LEN_W-1:0]    bytes_left, bytes_left_next;
  logic [TRIPLE_W-1:0] triple_pos, triple_pos_next;
  logic [BYTE_W-1:0]   held_red, held_red_next;
  logic [BYTE_W-1:0]   held_green, held_green_next;
  logic [CW-1:0]       column, column_next;
  logic [PIX_Y_W-1:0]  row, row_next;

  // width and mapping
  logic [XW-1:0]      w_raw;
  logic [EW-1:0]      w_eff;
  logic [EW-1:0]      col_a;
  logic [PIX_Y_W-1:0] row_a;
  logic [EW-1:0]      col_inc;
  logic [EW-1:0]      px;
  logic [LEN_W-1:0]   bl_dec;
  logic [LEN_W-1:0]   len_full;

  assign advance  = in_valid && !res_full;
  assign s_tready = !in_valid || !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // Clamp width to 1..MAX_WIDTH
  always_comb begin
    w_raw = XW'(display_width);
    if (w_raw == '0) begin
      w_raw = XW'(1);
    end
    if (w_raw > XW'(MAX_WIDTH)) begin
      w_raw = XW'(MAX_WIDTH);
    end
    w_eff = EW'(w_raw);
  end

  // Wrap a column left beyond a shrunk width, then place and advance
  always_comb begin
    if (EW'(column) >= w_eff) begin
      col_a = '0;
      row_a = row + PIX_Y_W'(1);
    end else begin
      col_a = EW'(column);
      row_a = row;
    end
    px      = row_a[0] ? (w_eff - col_a - EW'(1)) : col_a;
    col_inc = col_a + EW'(1);
  end

  assign bl_dec   = bytes_left - LEN_W'(1);
  assign len_full = {length_high, in_byte};

  always_comb begin
    phase_next       = phase;
    length_high_next = length_high;
    bytes_left_next  = bytes_left;
    triple_pos_next  = triple_pos;
    held_red_next    = held_red;
    held_green_next  = held_green;
    column_next      = column;
    row_next         = row;
    res_push         = 1'b0;
    res              = '0;

    if (advance) begin
      unique case (phase)
        PH_HDR0: phase_next = PH_HDR1;
        PH_HDR1: phase_next = PH_HDR2;
        PH_HDR2: begin
          length_high_next = in_byte;
          phase_next       = PH_HDR3;
        end
        PH_HDR3: begin
          bytes_left_next = len_full;
          triple_pos_next = TRIP_RED;
          column_next     = '0;
          row_next        = '0;
          if (len_full == '0) begin
            // empty frame ends right here
            phase_next    = PH_HDR0;
            res_push      = 1'b1;
            res.frame_end = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          unique case (triple_pos)
            TRIP_RED: begin
              held_red_next   = in_byte;
              triple_pos_next = TRIP_GREEN;
            end
            TRIP_GREEN: begin
              held_green_next = in_byte;
              triple_pos_next = TRIP_BLUE;
            end
            default: begin
              triple_pos_next = TRIP_RED;
              res_push        = 1'b1;
              res.pixel_valid = 1'b1;
              res.pixel_x     = PIX_X_W'(px);
              res.pixel_y     = row_a;
              res.red         = held_red;
              res.green       = held_green;
              res.blue        = in_byte;
              if (col_inc >= w_eff) begin
                column_next = '0;
                row_next    = row_a + PIX_Y_W'(1);
              end else begin
                column_next = CW'(col_inc);
                row_next    = row_a;
              end
            end
          endcase
          bytes_left_next = bl_dec;
          if (bl_dec == '0) begin
            phase_next      = PH_HDR0;
            triple_pos_next = TRIP_RED;
            res_push        = 1'b1;
            res.frame_end   = 1'b1;
          end
        end
        default: phase_next = PH_HDR1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      length_high <= '0;
      bytes_left  <= '0;
      triple_pos  <= TRIP_RED;
      held_red    <= '0;
      held_green  <= '0;
      column      <= '0;
      row         <= '0;
    end else begin
      phase       <= phase_next;
      length_high <= length_high_next;
      bytes_left  <= bytes_left_next;
      triple_pos  <= triple_pos_next;
      held_red    <= held_red_next;
      held_green  <= held_green_next;
      column      <= column_next;
      row         <= row_next;
    end
  end

endmodule

// ===== rtl/core/opc_sp_outbuf.sv =====
`timescale 1ns / 1ps
// Result register with one skid entry, packs results onto the output stream.
// Depends on opc_sp_pkg.
module opc_sp_outbuf (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               res_push,
  input  opc_sp_pkg::result_t                res,
  output logic                               res_full,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [opc_sp_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                               m_tuser,
  output logic                               m_tlast
);
  import opc_sp_pkg::*;

  result_t     head, skid;
  logic [1:0]  count;
  logic        pop;

  assign pop      = (count != 2'd0) && m_tready;
  assign res_full = (count == 2'd2);
  assign m_tvalid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (res_push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !res_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      if (count == 2'd0 || pop) begin
        head <= res;
      end else begin
        skid <= res;
      end
    end else if (pop && count == 2'd2) begin
      head <= skid;
    end
  end

  assign m_tdata = {OUT_DATA_W'({head.blue, head.green, head.red, head.pixel_y, head.pixel_x})};
  assign m_tuser = head.pixel_valid;
  assign m_tlast = head.frame_end;

endmodule

// ===== rtl/core/opc_serpentine_pixel_receiver_core.sv =====
`timescale 1ns / 1ps
// Top level of the serpentine pixel-stream receiver.
// Depends on opc_sp_pkg, opc_sp_cfg, opc_sp_parse and opc_sp_outbuf.
//
// Usage:
//   The slave stream (s_*) carries one byte of a pixel control stream per
//   word: four header bytes (channel, command, length high, length low)
//   followed by the payload. Every complete RGB triple becomes one master
//   word (m_*) with m_tuser high and serpentine x/y coordinates; the word
//   that ends a frame carries m_tlast. Header bytes and the first two bytes
//   of a triple produce no word unless they end a frame.
//   The APB port holds display_width (pixels per row, address 0); write it
//   only while no frame is in flight.
//   Throughput is one byte per clock while the result buffer has room. A
//   byte is held in the input register, parsed from there, and its result
//   word is registered into the result register. The result register has one
//   skid entry behind it, so the input keeps taking bytes while a word waits
//   at the output; s_tready drops only once both entries are occupied, and
//   never depends on m_tready in the same cycle.
//   Reset (rst, synchronous) empties both stages, expects a new header and
//   restores the width to 64.
module opc_serpentine_pixel_receiver_core #(
  parameter int MAX_WIDTH = opc_sp_pkg::DEF_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // slave stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [opc_sp_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] stream_byte
  // master stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [9:0] pixel_x, [24:10] pixel_y, [32:25] red, [40:33] green,
  // [48:41] blue, [55:49] zero
  output logic [opc_sp_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                               m_tuser,   // [0] pixel_valid
  output logic                               m_tlast,   // frame_end
  // APB configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [opc_sp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [opc_sp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [opc_sp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                               pready
);
  import opc_sp_pkg::*;

  logic [CFG_WIDTH_W-1:0] display_width;
  logic                   res_push;
  logic                   res_full;
  result_t                res;

  // Width register
  opc_sp_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .display_width (display_width)
  );

  // Register the byte, advance the header/payload state, map the pixel
  opc_sp_parse #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .display_width (display_width),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res)
  );

  // Hold results until the sink takes them
  opc_sp_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/opc_serpentine_pixel_receiver_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for opc_serpentine_pixel_receiver_core: drives pixel control
// byte streams and width settings, and checks every pixel/frame-end word it returns.
// Depends on opc_sp_pkg and the receiver RTL only.
module opc_serpentine_pixel_receiver_core_tb;
  import opc_sp_pkg::*;

  localparam int SETTLE_CYCLES = 8;     // two pipeline stages plus margin
  localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on any side
  localparam int PRINT_LIMIT   = 100;
  localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR = {REG_DISPLAY_WIDTH, 2'b00};

  logic clk;
  logic rst = 1'b1;

  // slave stream
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;  // [7:0] stream_byte
  // master stream
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // [9:0] x, [24:10] y, [32:25] r, [40:33] g, [48:41] b
  logic                  m_tuser;       // [0] pixel_valid
  logic                  m_tlast;       // frame_end
  // APB
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  opc_serpentine_pixel_receiver_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus and expectation stores
  logic [BYTE_W-1:0] stream_bytes[$];   // bytes waiting for the driver
  result_t           pixel_words_due[$]; // predicted output words, oldest first
  int                send_gap_pct   = 0;
  int                recv_stall_pct = 0;
  logic              byte_taken     = 1'b0;
  int                mismatch_count = 0;
  int                quiet_cycles   = 0;

  // Shadow of the parser state, reset values
  phase_t                  ph        = PH_HDR0;
  logic [BYTE_W-1:0]       len_hi    = '0;
  logic [LEN_W-1:0]        bytes_left = '0;
  logic [TRIPLE_W-1:0]     trip      = TRIP_RED;
  logic [BYTE_W-1:0]       held_r    = '0;
  logic [BYTE_W-1:0]       held_g    = '0;
  logic [CFG_WIDTH_W-1:0]  col_cnt   = '0;  // one bit wider than x so 1024 can be held
  logic [PIX_Y_W-1:0]      row_cnt   = '0;
  logic [CFG_WIDTH_W-1:0]  width_reg = WIDTH_RESET;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Advance the shadow parser by one byte; queue the word it causes, if any.
  task automatic parse_stream_byte(input logic [BYTE_W-1:0] b);
    result_t                word;
    logic [CFG_WIDTH_W-1:0] w;
    logic [CFG_WIDTH_W-1:0] px;
    logic                   emit;
    word = '0;
    emit = 1'b0;
    case (ph)
      PH_HDR0: ph = PH_HDR1;  // channel: ignored
      PH_HDR1: ph = PH_HDR2;  // command: ignored
      PH_HDR2: begin
        len_hi = b;
        ph     = PH_HDR3;
      end
      PH_HDR3: begin
        // length low: restart the pixel counters for the new frame
        bytes_left = {len_hi, b};
        trip       = TRIP_RED;
        col_cnt    = '0;
        row_cnt    = '0;
        if (bytes_left == '0) begin
          // empty frame ends right here
          word.frame_end = 1'b1;
          emit           = 1'b1;
          ph             = PH_HDR0;
        end else begin
          ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (trip == TRIP_RED) begin
          held_r = b;
          trip   = TRIP_GREEN;
        end else if (trip == TRIP_GREEN) begin
          held_g = b;
          trip   = TRIP_BLUE;
        end else begin
          // clamp the width: zero acts as one, anything above the max saturates
          if (width_reg == '0)
            w = CFG_WIDTH_W'(1);
          else if (width_reg > DEF_MAX_WIDTH)
            w = CFG_WIDTH_W'(DEF_MAX_WIDTH);
          else
            w = width_reg;
          trip = TRIP_RED;
          // width may have shrunk under a running frame: wrap before placing
          if (col_cnt >= w) begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
          end
          // odd rows run right to left
          px               = row_cnt[0] ? (w - col_cnt - 1'b1) : col_cnt;
          word.pixel_valid = 1'b1;
          word.pixel_x     = px[PIX_X_W-1:0];
          word.pixel_y     = row_cnt;
          word.red         = held_r;
          word.green       = held_g;
          word.blue        = b;
          emit             = 1'b1;
          col_cnt          = col_cnt + 1'b1;
          if (col_cnt >= w) begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
          end
        end
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) begin
          // last payload byte, whole triple or leftover, closes the frame
          word.frame_end = 1'b1;
          emit           = 1'b1;
          ph             = PH_HDR0;
          trip           = TRIP_RED;
        end
      end
      default: ph = PH_HDR1;  // unused code: behaves as the channel byte
    endcase
    if (emit) pixel_words_due.push_back(word);
  endtask

  // Compare one accepted output word against the oldest prediction.
  task automatic compare_pixel_word();
    result_t want;
    if (pixel_words_due.size() == 0) begin
      flag_mismatch($sformatf("word with nothing expected: tdata=%h tuser=%b tlast=%b",
                              m_tdata, m_tuser, m_tlast));
      return;
    end
    want = pixel_words_due.pop_front();
    if (m_tuser !== want.pixel_valid)
      flag_mismatch($sformatf("pixel_valid got %b want %b", m_tuser, want.pixel_valid));
    if (m_tdata[9:0] !== want.pixel_x)
      flag_mismatch($sformatf("pixel_x got %0d want %0d", m_tdata[9:0], want.pixel_x));
    if (m_tdata[24:10] !== want.pixel_y)
      flag_mismatch($sformatf("pixel_y got %0d want %0d", m_tdata[24:10], want.pixel_y));
    if (m_tdata[32:25] !== want.red)
      flag_mismatch($sformatf("red got %h want %h", m_tdata[32:25], want.red));
    if (m_tdata[40:33] !== want.green)
      flag_mismatch($sformatf("green got %h want %h", m_tdata[40:33], want.green));
    if (m_tdata[48:41] !== want.blue)
      flag_mismatch($sformatf("blue got %h want %h", m_tdata[48:41], want.blue));
    if (m_tdata[55:49] !== '0)
      flag_mismatch($sformatf("tdata pad bits got %h want 0", m_tdata[55:49]));
    if (m_tlast !== want.frame_end)
      flag_mismatch($sformatf("frame_end got %b want %b", m_tlast, want.frame_end));
  endtask

  // Driver: present the next byte once the current one is taken, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || byte_taken) begin
      if (stream_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        s_tdata  <= stream_bytes.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: check output words first, so a word leaving at the same edge
  // can never match a byte that only enters now.
  always @(posedge clk) begin
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) compare_pixel_word();
      if (s_tvalid && s_tready) parse_stream_byte(s_tdata);
    end
  end

  // Watchdog: stop if no word moves on either stream for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every byte is taken and every word is back, then let the pipe settle.
  task automatic wait_quiet();
    while (stream_bytes.size() != 0 || s_tvalid || pixel_words_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_width();
    logic [APB_DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WIDTH_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    if (got !== APB_DATA_W'(width_reg))
      flag_mismatch($sformatf("display_width read got %0d want %0d", got, width_reg));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write display_width, update the shadow copy at the write edge, read it back.
  task automatic write_width(input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WIDTH_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    width_reg = data[CFG_WIDTH_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    read_width();
  endtask

  // Queue one well-formed frame: random channel and command, random payload.
  task automatic queue_frame(input int len);
    logic [LEN_W-1:0] len_bits;
    len_bits = LEN_W'(len);
    stream_bytes.push_back(BYTE_W'($urandom_range(255)));
    stream_bytes.push_back(BYTE_W'($urandom_range(255)));
    stream_bytes.push_back(len_bits[15:8]);
    stream_bytes.push_back(len_bits[7:0]);
    for (int i = 0; i < len; i++) stream_bytes.push_back(BYTE_W'($urandom_range(255)));
  endtask

  // One random phase: set the width (upper bus bits sometimes junk), set the
  // idle mix, stream whole frames of mostly short lengths, then drain.
  task automatic run_phase(input int width, input int gap_pct, input int stall_pct,
                           input int n_bytes);
    logic [APB_DATA_W-1:0] word;
    int                    queued;
    int                    roll;
    int                    len;
    word = $urandom_range(1) ? APB_DATA_W'($urandom) : '0;
    word[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'(width);
    write_width(word);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    queued = 0;
    while (queued < n_bytes) begin
      roll = $urandom_range(99);
      if (roll < 8)
        len = 0;
      else if (roll < 78)
        len = $urandom_range(45, 1);
      else if (roll < 93)
        len = 3 * $urandom_range(15, 1);   // no leftover bytes
      else
        len = 256 + $urandom_range(40);    // nonzero length high byte
      queue_frame(len);
      queued += len + 4;
    end
    wait_quiet();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    read_width();  // reset value

    // Directed: empty frame, then a frame that gets a narrower width mid-way
    stream_bytes = '{8'hFF, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'hFF, 8'h00, 8'h07,
                     8'h00, 8'hFF, 8'h80};
    wait_quiet();
    // width 0 (acts as 1) with junk in the upper bus bits; column 1 must wrap
    write_width(32'hFFFF_F800);
    // second pixel lands on row 1, then one leftover byte ends the frame
    stream_bytes = '{8'hFF, 8'h00, 8'h01, 8'h55};
    wait_quiet();
    // width above the max saturates; last byte completes a triple and the frame
    write_width(32'h0000_07FF);
    stream_bytes = '{8'h7E, 8'h81, 8'h00, 8'h03, 8'hFF, 8'h00, 8'hFF};
    wait_quiet();

    // Random phases across the idle mixes and a spread of widths
    run_phase(1, 0, 0, 140);
    run_phase(3, 65, 0, 140);
    run_phase(5, 0, 65, 140);
    run_phase(2, 31, 31, 140);
    run_phase($urandom_range(9, 1), 0, 0, 140);
    run_phase(7, 65, 0, 140);
    run_phase(1024, 0, 65, 140);
    run_phase($urandom_range(16, 4), 31, 31, 140);

    // Width 1 puts the first pixel on row 0 and moves on to row 1; a saturated
    // width then starts the odd row at the far end (x = 1023, then 1022)
    write_width(32'h0000_0001);
    send_gap_pct   = 31;
    recv_stall_pct = 31;
    stream_bytes = '{8'h3C, 8'hC3, 8'h00, 8'h0A, 8'h11, 8'h22, 8'h33};
    wait_quiet();
    write_width(32'h5A5A_A401);
    stream_bytes = '{8'h44, 8'h55, 8'h66, 8'h77, 8'h88, 8'h99, 8'hAA};
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
